/* design/tprt_pkg.sv */
// shared types, constants and decode function of the touch point tracker
package tprt_pkg;

    localparam int RAW_SLOTS   = 5;
    localparam int IN_TDATA_W  = 176;
    localparam int OUT_TDATA_W = 56;
    localparam int OUT_TUSER_W = 3;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [15:0] PANEL_WIDTH_RST  = 16'd600;
    localparam logic [15:0] PANEL_HEIGHT_RST = 16'd1024;

    localparam logic [7:0]  POLL_WINDOW   = 8'd10;
    localparam logic [7:0]  POLL_LIMIT    = 8'd240;
    localparam logic [3:0]  MOD10_TOP     = 4'd9;
    localparam logic [7:0]  READY_BIT     = 8'h80;
    localparam logic [7:0]  COUNT_MASK    = 8'h0F;
    localparam logic [7:0]  TOUCH_BITS    = 8'hC0;
    localparam logic [7:0]  REL16_MASK    = 8'h8F;
    localparam logic [7:0]  REL8_MASK     = 8'h1F;
    localparam logic [7:0]  KEEP_ON_CLEAR = 8'hE0;
    localparam logic [7:0]  PRESSED_CLR   = 8'h7F;
    localparam logic [15:0] NO_POINT      = 16'hFFFF;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_KIND      = 2'd0,
        CFG_LANDSCAPE = 2'd1,
        CFG_WIDTH     = 2'd2,
        CFG_HEIGHT    = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
    } xy_t;

    typedef struct packed {
        logic        kind;
        logic        landscape;
        logic [15:0] width;
        logic [15:0] height;
    } cfg_t;

    // tracker registers outside the point memory
    typedef struct packed {
        logic [7:0] poll;
        logic [3:0] mod10;
        logic [7:0] status;
    } trk_state_t;

    // per-item flags carried along with every slot word
    typedef struct packed {
        logic [7:0] status;
        logic       new_touch;
        logic       clear_req;
        logic       sampled;
    } item_flags_t;

    function automatic xy_t decode_point(input logic [31:0] raw, input cfg_t cfg);
        logic [7:0]  b0, b1, b2, b3;
        logic [15:0] lo, hi;
        xy_t         r;
        b0 = raw[7:0];
        b1 = raw[15:8];
        b2 = raw[23:16];
        b3 = raw[31:24];
        if (cfg.kind) begin
            lo = {b1, b0};
            hi = {b3, b2};
            if (cfg.landscape) begin
                r.x = lo;
                r.y = hi;
            end else begin
                r.y = lo;
                r.x = cfg.width - hi;
            end
        end else begin
            lo = {4'd0, b0[3:0], b1};
            hi = {4'd0, b2[3:0], b3};
            if (cfg.landscape) begin
                r.y = lo;
                r.x = hi;
            end else begin
                r.x = cfg.width - lo;
                r.y = hi;
            end
        end
        return r;
    endfunction

endpackage

/* design/tprt_item_ctrl.sv */
// per-item decision logic: poll admission, decode, panel check, release
module tprt_item_ctrl
    import tprt_pkg::*;
#(
    parameter int MAX_POINTS = 5
) (
    input  logic [7:0]    call_mode,
    input  logic [7:0]    status_byte,
    input  logic [31:0]   point_raw [RAW_SLOTS],
    input  cfg_t          cfg,
    input  trk_state_t    cur,
    output trk_state_t    nxt,
    output item_flags_t   flags,
    output xy_t           cand [MAX_POINTS],
    output logic [MAX_POINTS-1:0] use_cand,
    output logic          take_old0
);

    localparam int LAST_SLOT = MAX_POINTS - 1;
    localparam int SECOND    = (MAX_POINTS > 1) ? 1 : 0;

    logic [7:0] pc1, mode, mode2, mask8, sw_dec, sw1, sw2, poll_n;
    logic [3:0] m1, cnt;
    logic       samp, dec, out_panel, restore, rel, clr0, hold_cnt;
    xy_t        d [MAX_POINTS];
    logic [MAX_POINTS-1:0] vld;

    always_comb begin
        pc1  = cur.poll + 8'd1;
        m1   = (cur.poll == 8'hFF || cur.mod10 == MOD10_TOP) ? 4'd0 : cur.mod10 + 4'd1;
        samp = (m1 == 4'd0) || (pc1 < POLL_WINDOW);
        mode = samp ? status_byte : call_mode;
        cnt  = mode[3:0];
        dec  = samp && (cnt != 4'd0) && ({4'd0, cnt} <= 8'(MAX_POINTS));
        mask8  = 8'((9'd1 << cnt) - 9'd1);
        sw_dec = mask8 | TOUCH_BITS;

        for (int i = 0; i < MAX_POINTS; i++) begin
            d[i]   = decode_point(point_raw[i], cfg);
            vld[i] = dec && mask8[i];
        end

        out_panel = (d[0].x > cfg.width) || (d[0].y > cfg.height);
        restore   = dec && out_panel && (cnt == 4'd1);
        mode2     = restore ? READY_BIT : mode;
        sw1       = (dec && !restore) ? sw_dec : cur.status;
        rel       = cfg.kind ? ((mode2 & REL16_MASK) == READY_BIT)
                             : ((mode2 & REL8_MASK) == 8'd0);
        clr0      = rel && !sw1[7];
        if (!rel) begin
            sw2 = sw1;
        end else if (sw1[7]) begin
            sw2 = sw1 & PRESSED_CLR;
        end else begin
            sw2 = sw1 & KEEP_ON_CLEAR;
        end

        // counter restarts whenever a decode is kept
        hold_cnt  = dec && !restore;
        poll_n    = hold_cnt ? 8'd0 : pc1;
        nxt.poll  = (poll_n > POLL_LIMIT) ? POLL_WINDOW : poll_n;
        nxt.mod10 = (hold_cnt || poll_n > POLL_LIMIT) ? 4'd0 : m1;
        nxt.status = sw2;

        flags.status    = sw2;
        flags.new_touch = dec;
        flags.clear_req = samp && cfg.kind && mode[7]
                       && ({4'd0, cnt} <= 8'(MAX_POINTS));
        flags.sampled   = samp;

        for (int i = 0; i < MAX_POINTS; i++) begin
            cand[i]     = d[i];
            use_cand[i] = vld[i];
        end

        // slot 0: release, in-panel decode, second point, or backup restore
        priority if (clr0) begin
            cand[0]     = '{x: NO_POINT, y: NO_POINT};
            use_cand[0] = 1'b1;
        end else if (dec && !out_panel) begin
            cand[0]     = d[0];
            use_cand[0] = 1'b1;
        end else if (dec && cnt != 4'd1) begin
            cand[0]     = d[SECOND];
            use_cand[0] = 1'b1;
        end else if (restore) begin
            cand[0]     = d[LAST_SLOT];
            use_cand[0] = vld[LAST_SLOT];
        end else begin
            use_cand[0] = 1'b0;
        end

        // backup copy of the old slot 0 lands in the last slot
        take_old0 = (MAX_POINTS > 1) && dec && !vld[LAST_SLOT];
    end

endmodule

/* design/touch_point_report_tracker_unit.sv */
// top level of the touch point tracker: handshakes, point memory, slot sequencer
//
// input stream (s_*): one word per controller poll, carrying the caller's mode
// byte, the controller status byte and the raw bytes of five touch points
// output stream (m_*): MAX_POINTS words per accepted poll, slot 0 first, tlast
// on the final slot; each word gives the slot's stored x/y, the status word
// and the item flags in tuser
// config port: cfg_we writes cfg_wdata into register cfg_addr at the clock edge
// the first slot word of a taken input word goes through stage a, stage b and
// the output register; the point memory has a single read and a single write
// port and, while the output is not stalled, the sequencer moves one slot per cycle
// the next poll is taken while the previous poll's last slots are still in flight
// reset (aresetn low, synchronous): stream empty, poll counter and status word
// zero, all stored points read as zero, config back to its reset values
// a stalled receiver (m_tready low) freezes the whole pipe, memory included,
// and s_tready drops until the output register can move again
module touch_point_report_tracker_unit
    import tprt_pkg::*;
#(
    parameter int MAX_POINTS = 5
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // config write port
    input  logic                    cfg_we,
    input  logic [CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [CFG_DATA_W-1:0]   cfg_wdata,
    // input stream
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // lsb up: call_mode[8], status_byte[8], point0_raw[32] .. point4_raw[32]
    input  logic [IN_TDATA_W-1:0]   s_tdata,
    // output stream
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // lsb up: slot[3], point_x[16], point_y[16], touch_status[8], zero pad[13]
    output logic [OUT_TDATA_W-1:0]  m_tdata,
    // lsb up: new_touch, clear_request, sampled
    output logic [OUT_TUSER_W-1:0]  m_tuser,
    output logic                    m_tlast
);

    localparam int KW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam logic [KW-1:0] LAST_K = KW'(MAX_POINTS - 1);

    // config registers
    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.kind      <= 1'b0;
            cfg_reg.landscape <= 1'b0;
            cfg_reg.width     <= PANEL_WIDTH_RST;
            cfg_reg.height    <= PANEL_HEIGHT_RST;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_KIND:      cfg_reg.kind      <= cfg_wdata[0];
                CFG_LANDSCAPE: cfg_reg.landscape <= cfg_wdata[0];
                CFG_WIDTH:     cfg_reg.width     <= cfg_wdata;
                CFG_HEIGHT:    cfg_reg.height    <= cfg_wdata;
            endcase
        end
    end

    // unpack the input word
    logic [7:0]  in_call_mode, in_status_byte;
    logic [31:0] in_raw [RAW_SLOTS];

    always_comb begin
        in_call_mode   = s_tdata[7:0];
        in_status_byte = s_tdata[15:8];
        for (int i = 0; i < RAW_SLOTS; i++) begin
            in_raw[i] = s_tdata[16 + 32*i +: 32];
        end
    end

    // handshake and pipe advance
    logic adv, acc;
    logic a_valid_reg;
    logic [KW-1:0] a_k_reg;

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv && (!a_valid_reg || a_k_reg == LAST_K);
    assign acc      = s_tvalid && s_tready;

    // item decisions are made at accept time and update the tracker registers
    trk_state_t  trk_reg, trk_next;
    item_flags_t it_flags;
    xy_t         it_cand [MAX_POINTS];
    logic [MAX_POINTS-1:0] it_use;
    logic        it_take;

    tprt_item_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
        .call_mode   (in_call_mode),
        .status_byte (in_status_byte),
        .point_raw   (in_raw),
        .cfg         (cfg_reg),
        .cur         (trk_reg),
        .nxt         (trk_next),
        .flags       (it_flags),
        .cand        (it_cand),
        .use_cand    (it_use),
        .take_old0   (it_take)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trk_reg <= '0;
        end else if (acc) begin
            trk_reg <= trk_next;
        end
    end

    // stage a: item context, one memory read per slot
    item_flags_t a_flags_reg;
    xy_t         a_cand_reg [MAX_POINTS];
    logic [MAX_POINTS-1:0] a_use_reg;
    logic        a_take_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            a_k_reg     <= '0;
        end else if (adv) begin
            if (acc) begin
                a_valid_reg <= 1'b1;
                a_k_reg     <= '0;
            end else if (a_valid_reg) begin
                a_valid_reg <= (a_k_reg != LAST_K);
                // slot index wraps so it never leaves the memory range
                a_k_reg     <= (a_k_reg == LAST_K) ? '0 : a_k_reg + KW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && acc) begin
            a_flags_reg <= it_flags;
            a_cand_reg  <= it_cand;
            a_use_reg   <= it_use;
            a_take_reg  <= it_take;
        end
    end

    // point memory, x and y side by side; entries never written read as zero
    xy_t  mem [MAX_POINTS];
    logic [MAX_POINTS-1:0] mem_vld_reg;
    xy_t  rd_q_reg;
    logic rd_vld_reg;
    logic fwd_hit_reg;
    xy_t  fwd_data_reg;

    // stage b: merge with the stored point, write back, load the output word
    logic        b_valid_reg;
    logic [KW-1:0] b_k_reg;
    item_flags_t b_flags_reg;
    xy_t         b_cand_reg;
    logic        b_use_reg, b_take_reg;
    xy_t         old0_reg;
    xy_t         b_old, b_final;
    logic        b_wr;

    always_comb begin
        if (fwd_hit_reg) begin
            b_old = fwd_data_reg;
        end else if (rd_vld_reg) begin
            b_old = rd_q_reg;
        end else begin
            b_old = '0;
        end
        if (b_use_reg) begin
            b_final = b_cand_reg;
        end else if (b_take_reg) begin
            b_final = old0_reg;
        end else begin
            b_final = b_old;
        end
        b_wr = adv && b_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rd_q_reg     <= mem[a_k_reg];
            rd_vld_reg   <= mem_vld_reg[a_k_reg];
            // write to the same entry in this cycle is not yet in the array
            fwd_hit_reg  <= b_valid_reg && (b_k_reg == a_k_reg);
            fwd_data_reg <= b_final;
        end
        if (b_wr) begin
            mem[b_k_reg] <= b_final;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mem_vld_reg <= '0;
        end else if (b_wr) begin
            mem_vld_reg[b_k_reg] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (adv) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b_k_reg     <= a_k_reg;
            b_flags_reg <= a_flags_reg;
            b_cand_reg  <= a_cand_reg[a_k_reg];
            b_use_reg   <= a_use_reg[a_k_reg];
            b_take_reg  <= a_take_reg && (a_k_reg == LAST_K);
        end
        // keep the pre-item slot 0 for the backup copy
        if (b_wr && b_k_reg == '0) begin
            old0_reg <= b_old;
        end
    end

    // output register
    logic m_valid_reg;
    logic [OUT_TDATA_W-1:0] m_data_reg;
    logic [OUT_TUSER_W-1:0] m_user_reg;
    logic m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_wr) begin
            m_data_reg <= {5'd0, 8'd0, b_flags_reg.status, b_final.y, b_final.x,
                           3'(b_k_reg)};
            m_user_reg <= {b_flags_reg.sampled, b_flags_reg.clear_req,
                           b_flags_reg.new_touch};
            m_last_reg <= (b_k_reg == LAST_K);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

/* design/tprt_checker.sv */
// port-level checker for the touch point tracker, bound to the top level
module tprt_checker
    import tprt_pkg::*;
#(
    parameter int MAX_POINTS = 5
) (
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    m_tvalid,
    input logic                    m_tready,
    input logic [OUT_TDATA_W-1:0]  m_tdata,
    input logic [OUT_TUSER_W-1:0]  m_tuser,
    input logic                    m_tlast
);

    logic m_xfer;
    assign m_xfer = m_tvalid && m_tready;

    // stalled word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("output word changed while stalled");

    // slots of one poll follow each other without a gap
    a_next_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_xfer && !m_tlast |=> m_tvalid && (m_tdata[2:0] == $past(m_tdata[2:0]) + 3'd1))
        else $error("slot sequence broken");

    // status and flags are the same for every slot of a poll
    a_item_const: assert property (@(posedge aclk) disable iff (!aresetn)
        m_xfer && !m_tlast |=> $stable(m_tuser) && $stable(m_tdata[50:35]))
        else $error("item flags changed inside a poll");

    // tlast only on the final slot
    a_last_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tdata[2:0] == 3'(MAX_POINTS - 1))))
        else $error("tlast on wrong slot");

    // reset empties the output
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind touch_point_report_tracker_unit tprt_checker #(.MAX_POINTS(MAX_POINTS)) u_tprt_checker (.*);
